@@ rtl/core/ugsi_pkg.sv @@
package ugsi_pkg;

  // Fixed field widths
  localparam int COORD_W = 24;
  localparam int ID_W    = 32;
  localparam int RAD_W   = 23;
  localparam int INV_W   = 24;
  localparam int DIM_W   = 6;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 3;

  // Coordinate path: radius box edge, difference to origin, cell number
  localparam int POS_W  = COORD_W + 1;
  localparam int DIF_W  = POS_W + 1;
  localparam int CELL_W = DIF_W + 1;
  localparam int FRAC_SHIFT = 24;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_RECT   = 2'd2,
    OP_RADIUS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_FULL  = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_INV_CELL = 3'd2,
    CFG_ACROSS   = 3'd3,
    CFG_DOWN     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic [ID_W-1:0]            entity_id;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  corner_x;
    logic signed [COORD_W-1:0]  corner_y;
    logic [RAD_W-1:0]           search_radius;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            found;
    logic            last;
    logic [1:0]      status;
  } result_t;

endpackage

@@ rtl/core/ugsi_cell_map.sv @@
// Two-stage coordinate to cell mapping: magnitude, then scaled product.
module ugsi_cell_map (
  input  logic                                clk_i,
  input  logic signed [ugsi_pkg::POS_W-1:0]   pos_i,
  input  logic signed [ugsi_pkg::COORD_W-1:0] org_i,
  input  logic [ugsi_pkg::INV_W-1:0]          inv_i,
  output logic signed [ugsi_pkg::CELL_W-1:0]  cell_o
);

  localparam int PW = ugsi_pkg::DIF_W + ugsi_pkg::INV_W;

  logic signed [ugsi_pkg::DIF_W-1:0] dif;
  logic [ugsi_pkg::DIF_W-1:0]        mag_d, mag_q;
  logic                              neg_q;
  logic [PW-1:0]                     prod;
  logic [ugsi_pkg::CELL_W-1:0]       scaled;

  assign dif   = ugsi_pkg::DIF_W'(pos_i) - ugsi_pkg::DIF_W'(org_i);
  assign mag_d = dif[ugsi_pkg::DIF_W-1] ? ugsi_pkg::DIF_W'(-dif) : ugsi_pkg::DIF_W'(dif);
  assign prod  = PW'(mag_q) * PW'(inv_i);
  assign scaled = {1'b0, prod[PW-1:ugsi_pkg::FRAC_SHIFT]};

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= dif[ugsi_pkg::DIF_W-1];
    cell_o <= neg_q ? $signed(-scaled) : $signed(scaled);
  end

endmodule

@@ rtl/core/uniform_grid_spatial_index_top.sv @@
// Channel  | Signals                              | Handshake
// ---------+--------------------------------------+-------------------------------
// item     | start_i, busy_o, item_i              | beat when start_i && !busy_o
// result   | result_valid_o, result_o             | strobe, one cycle, no stall
// config   | cfg_valid_i, cfg_ready_o, cfg_*_i    | beat when valid && ready (idle)
//
// Insert: map the point, check bounds, read the fill count, write the id (an out of
// bounds point ends after the check). Query: map both corners, clamp the range (an empty
// range ends there), then walk the covered cells, reading each fill count and then each
// stored id; truncation ends the walk early. Clear sweeps every cell of the fill memory.
// Reset: a clearing pass over all MAX_COLUMNS*MAX_ROWS cells runs first with busy_o high.
// Results cannot be stalled; busy_o falls with the last beat; config waits while busy.
module uniform_grid_spatial_index_top #(
  parameter int MAX_COLUMNS  = 32,
  parameter int MAX_ROWS     = 32,
  parameter int BIN_CAPACITY = 8,
  parameter int RESULT_CAP   = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  ugsi_pkg::item_t                item_i,
  output logic                           result_valid_o,
  output ugsi_pkg::result_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ugsi_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [ugsi_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int NCELL = MAX_COLUMNS * MAX_ROWS;
  localparam int NMEM  = NCELL * BIN_CAPACITY;
  localparam int AW    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int MW    = (NMEM > 1) ? $clog2(NMEM) : 1;
  localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int FW    = $clog2(BIN_CAPACITY + 1);
  localparam int NW    = $clog2(RESULT_CAP + 1);
  localparam int CW    = ugsi_pkg::CELL_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_CONV = 4'd2;
  localparam logic [3:0] S_ICHK = 4'd3;
  localparam logic [3:0] S_IRD  = 4'd4;
  localparam logic [3:0] S_IWR  = 4'd5;
  localparam logic [3:0] S_QSET = 4'd6;
  localparam logic [3:0] S_QADR = 4'd7;
  localparam logic [3:0] S_QRF  = 4'd8;
  localparam logic [3:0] S_QFW  = 4'd9;
  localparam logic [3:0] S_QMR  = 4'd10;
  localparam logic [3:0] S_QMD  = 4'd11;
  localparam logic [3:0] S_QEND = 4'd12;

  // Configuration registers
  logic signed [ugsi_pkg::COORD_W-1:0] org_x_q, org_y_q;
  logic [ugsi_pkg::INV_W-1:0]          inv_q;
  logic [ugsi_pkg::DIM_W-1:0]          across_q, down_q;

  // Control state
  logic [3:0]        state_q, state_d;
  logic              clr_emit_q, clr_emit_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [2:0]        cnt_q, cnt_d;
  ugsi_pkg::item_t   item_q;
  logic              pend_v_q, pend_v_d;
  logic [NW-1:0]     n_q, n_d;
  logic              res_v_q, res_v_d;
  ugsi_pkg::result_t res_q, res_d;

  // Hold config writes off while an item is in flight
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      inv_q    <= ugsi_pkg::INV_W'(65536);
      across_q <= ugsi_pkg::DIM_W'(32);
      down_q   <= ugsi_pkg::DIM_W'(32);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ugsi_pkg::CFG_ORIGIN_X: org_x_q  <= cfg_data_i;
        ugsi_pkg::CFG_ORIGIN_Y: org_y_q  <= cfg_data_i;
        ugsi_pkg::CFG_INV_CELL: inv_q    <= cfg_data_i;
        ugsi_pkg::CFG_ACROSS:   across_q <= cfg_data_i[ugsi_pkg::DIM_W-1:0];
        ugsi_pkg::CFG_DOWN:     down_q   <= cfg_data_i[ugsi_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid size in use: zero acts as one, above the maximum clips
  logic [CW-1:0] cols_u, rows_u;
  always_comb begin
    if (across_q == '0) cols_u = CW'(1);
    else if (CW'(across_q) > CW'(MAX_COLUMNS)) cols_u = CW'(MAX_COLUMNS);
    else cols_u = CW'(across_q);
    if (down_q == '0) rows_u = CW'(1);
    else if (CW'(down_q) > CW'(MAX_ROWS)) rows_u = CW'(MAX_ROWS);
    else rows_u = CW'(down_q);
  end

  // Payload registers
  logic signed [CW-1:0] cell_q [4];
  logic [AW-1:0]        cur_q, cur_d;
  logic [XW-1:0]        cx_q, cx_d, lx_q, lx_d, hx_q, hx_d;
  logic [YW-1:0]        cy_q, cy_d, hy_q, hy_d;
  logic [FW-1:0]        f_q, f_d, e_q, e_d;
  logic [ugsi_pkg::ID_W-1:0] pend_q, pend_d;

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // Coordinate feed into the mapper, one per cycle: x0, y0, x1, y1
  logic signed [ugsi_pkg::POS_W-1:0]   px, py, qx, qy, rr, pos_sel;
  logic signed [ugsi_pkg::COORD_W-1:0] org_sel;
  logic signed [CW-1:0]                map_cell;
  logic [2:0]                          cap_idx, last_cnt;

  always_comb begin
    rr = $signed({2'b00, item_q.search_radius});
    if (item_q.operation == ugsi_pkg::OP_RADIUS) begin
      px = ugsi_pkg::POS_W'(item_q.point_x) - rr;
      py = ugsi_pkg::POS_W'(item_q.point_y) - rr;
      qx = ugsi_pkg::POS_W'(item_q.point_x) + rr;
      qy = ugsi_pkg::POS_W'(item_q.point_y) + rr;
    end else begin
      px = ugsi_pkg::POS_W'(item_q.point_x);
      py = ugsi_pkg::POS_W'(item_q.point_y);
      qx = ugsi_pkg::POS_W'(item_q.corner_x);
      qy = ugsi_pkg::POS_W'(item_q.corner_y);
    end
    case (cnt_q[1:0])
      2'd0:    pos_sel = px;
      2'd1:    pos_sel = py;
      2'd2:    pos_sel = qx;
      default: pos_sel = qy;
    endcase
    org_sel = cnt_q[0] ? org_y_q : org_x_q;
  end

  assign cap_idx  = cnt_q - 3'd2;
  assign last_cnt = (item_q.operation == ugsi_pkg::OP_INSERT) ? 3'd3 : 3'd5;

  ugsi_cell_map u_map (
    .clk_i  (clk_i),
    .pos_i  (pos_sel),
    .org_i  (org_sel),
    .inv_i  (inv_q),
    .cell_o (map_cell)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_CONV && cnt_q >= 3'd2) begin
      cell_q[cap_idx[1:0]] <= map_cell;
    end
  end

  // Bin memories: fill count per cell and member ids
  logic [FW-1:0]             fill_mem [NCELL];
  logic [FW-1:0]             fill_rd_q;
  logic                      fill_we;
  logic [AW-1:0]             fill_wa;
  logic [FW-1:0]             fill_wd;
  logic [ugsi_pkg::ID_W-1:0] mem_mem [NMEM];
  logic [ugsi_pkg::ID_W-1:0] mem_rd_q;
  logic                      mem_we;
  logic [MW-1:0]             mem_wa, mem_ra;

  assign mem_wa = MW'(cur_q) * MW'(BIN_CAPACITY) + MW'(fill_rd_q);
  assign mem_ra = MW'(cur_q) * MW'(BIN_CAPACITY) + MW'(e_q);

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_rd_q <= fill_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_mem[mem_wa] <= item_q.entity_id;
    mem_rd_q <= mem_mem[mem_ra];
  end

  // Bounds and clamp on the mapped cells
  logic signed [CW-1:0] lx_s, ly_s, hx_s, hy_s;
  logic                 oob, q_empty;
  logic [AW-1:0]        ins_addr, walk_addr;

  always_comb begin
    oob = (cell_q[0] < 0) || (cell_q[1] < 0) ||
          (cell_q[0] >= $signed(cols_u)) || (cell_q[1] >= $signed(rows_u));
    lx_s = (cell_q[0] < 0) ? '0 : cell_q[0];
    ly_s = (cell_q[1] < 0) ? '0 : cell_q[1];
    hx_s = (cell_q[2] > $signed(cols_u - CW'(1))) ? $signed(cols_u - CW'(1)) : cell_q[2];
    hy_s = (cell_q[3] > $signed(rows_u - CW'(1))) ? $signed(rows_u - CW'(1)) : cell_q[3];
    q_empty = (lx_s > hx_s) || (ly_s > hy_s);
    ins_addr  = AW'(cell_q[1][YW-1:0]) * AW'(MAX_COLUMNS) + AW'(cell_q[0][XW-1:0]);
    walk_addr = AW'(cy_q) * AW'(MAX_COLUMNS) + AW'(cx_q);
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_emit_d = clr_emit_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    n_d        = n_q;
    cur_d      = cur_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    lx_d       = lx_q;
    hx_d       = hx_q;
    hy_d       = hy_q;
    f_d        = f_q;
    e_d        = e_q;
    res_v_d    = 1'b0;
    res_d      = '{found_id: '0, found: 1'b0, last: 1'b1, status: ugsi_pkg::ST_OK};
    fill_we    = 1'b0;
    fill_wa    = cur_q;
    fill_wd    = '0;
    mem_we     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          clr_d = '0;
          clr_emit_d = 1'b1;
          state_d = (item_i.operation == ugsi_pkg::OP_CLEAR) ? S_CLR : S_CONV;
        end
      end
      S_CLR: begin
        fill_we = 1'b1;
        fill_wa = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(NCELL - 1)) begin
          res_v_d = clr_emit_q;
          state_d = S_IDLE;
        end
      end
      S_CONV: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == last_cnt) begin
          state_d = (item_q.operation == ugsi_pkg::OP_INSERT) ? S_ICHK : S_QSET;
        end
      end
      S_ICHK: begin
        cur_d = ins_addr;
        if (oob) begin
          res_v_d = 1'b1;
          res_d.status = ugsi_pkg::ST_OOB;
          state_d = S_IDLE;
        end else begin
          state_d = S_IRD;
        end
      end
      S_IRD: state_d = S_IWR;
      S_IWR: begin
        res_v_d = 1'b1;
        state_d = S_IDLE;
        if (fill_rd_q >= FW'(BIN_CAPACITY)) begin
          res_d.status = ugsi_pkg::ST_FULL;
        end else begin
          mem_we  = 1'b1;
          fill_we = 1'b1;
          fill_wd = fill_rd_q + FW'(1);
        end
      end
      S_QSET: begin
        pend_v_d = 1'b0;
        n_d      = '0;
        lx_d     = lx_s[XW-1:0];
        hx_d     = hx_s[XW-1:0];
        hy_d     = hy_s[YW-1:0];
        cx_d     = lx_s[XW-1:0];
        cy_d     = ly_s[YW-1:0];
        if (q_empty) begin
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_QADR;
        end
      end
      S_QADR: begin
        cur_d   = walk_addr;
        state_d = S_QRF;
      end
      S_QRF: state_d = S_QFW;
      S_QFW: begin
        f_d = fill_rd_q;
        e_d = '0;
        if (fill_rd_q != '0) state_d = S_QMR;
        else if (cx_q != hx_q) begin
          cx_d = cx_q + XW'(1);
          state_d = S_QADR;
        end else if (cy_q != hy_q) begin
          cy_d = cy_q + YW'(1);
          cx_d = lx_q;
          state_d = S_QADR;
        end else state_d = S_QEND;
      end
      S_QMR: state_d = S_QMD;
      S_QMD: begin
        if (n_q == NW'(RESULT_CAP)) begin
          // Cap reached with another id pending: close with truncation
          res_v_d = 1'b1;
          res_d   = '{found_id: pend_q, found: 1'b1, last: 1'b1,
                      status: ugsi_pkg::ST_TRUNC};
          state_d = S_IDLE;
        end else begin
          res_v_d = pend_v_q;
          res_d   = '{found_id: pend_q, found: 1'b1, last: 1'b0,
                      status: ugsi_pkg::ST_OK};
          pend_d   = mem_rd_q;
          pend_v_d = 1'b1;
          n_d      = n_q + NW'(1);
          if (e_q + FW'(1) != f_q) begin
            e_d = e_q + FW'(1);
            state_d = S_QMR;
          end else if (cx_q != hx_q) begin
            cx_d = cx_q + XW'(1);
            state_d = S_QADR;
          end else if (cy_q != hy_q) begin
            cy_d = cy_q + YW'(1);
            cx_d = lx_q;
            state_d = S_QADR;
          end else state_d = S_QEND;
        end
      end
      S_QEND: begin
        res_v_d = 1'b1;
        if (pend_v_q) begin
          res_d = '{found_id: pend_q, found: 1'b1, last: 1'b1, status: ugsi_pkg::ST_OK};
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_emit_q <= 1'b0;
      clr_q      <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      n_q        <= '0;
      res_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_emit_q <= clr_emit_d;
      clr_q      <= clr_d;
      cnt_q      <= cnt_d;
      pend_v_q   <= pend_v_d;
      n_q        <= n_d;
      res_v_q    <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) item_q <= item_i;
    res_q  <= res_d;
    pend_q <= pend_d;
    cur_q  <= cur_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    lx_q   <= lx_d;
    hx_q   <= hx_d;
    hy_q   <= hy_d;
    f_q    <= f_d;
    e_q    <= e_d;
  end

endmodule

@@ rtl/core/ugsi_checker.sv @@
module ugsi_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        result_valid_o,
  input ugsi_pkg::result_t           result_o
);

  // Not-found beats always close an item
  a_nofind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.found |-> result_o.last)
    else $error("not-found beat without last");

  // Error or truncation status only on the closing beat
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status != ugsi_pkg::ST_OK) |-> result_o.last)
    else $error("nonzero status before last");

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // More beats to come means the block is still working
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("non-last beat while idle");

endmodule

bind uniform_grid_spatial_index_top ugsi_checker u_ugsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
